[rtl/assert_macros.svh]
// assertion macros shared by the deframer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SBPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sbpd assertion failed");

// condition must never be seen at a clock edge outside reset
`define SBPD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sbpd forbidden condition seen");

`else

`define SBPD_ASSERT(lbl, clk, rst_n, prop)
`define SBPD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/sbpd_pkg.sv]
// types and constants of the sync byte packet deframer
// no dependencies; used by sbpd_collector, sbpd_out_reg and the top level
package sbpd_pkg;

    // byte position within a packet, zero while hunting for sync
    typedef logic [3:0] t_pos;

    localparam logic [7:0] SYNC_RESET = 8'hAA;
    // bytes collected before the checksum byte
    localparam t_pos BODY_LEN = 4'd10;
    // bytes kept for the result: body without the sync byte
    localparam int SHIFT_LEN = 9;

    // one decoded packet
    typedef struct packed {
        logic [7:0]         command;
        logic signed [15:0] setpoint_one;
        logic signed [15:0] setpoint_two;
        logic signed [15:0] setpoint_three;
        logic signed [15:0] setpoint_four;
        logic               checksum_ok;
    } t_result;

    // packet completion from collector to output stage
    typedef struct packed {
        logic    done;
        t_result data;
    } t_result_xfer;

endpackage

[rtl/sbpd_byte_if.sv]
// valid/ready channel carrying one received byte
// no dependencies
interface sbpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/sbpd_result_if.sv]
// valid/ready channel carrying one decoded packet
// no dependencies
interface sbpd_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         command;
    logic signed [15:0] setpoint_one;
    logic signed [15:0] setpoint_two;
    logic signed [15:0] setpoint_three;
    logic signed [15:0] setpoint_four;
    logic               checksum_ok;

    modport source (
        output valid, output command, output setpoint_one, output setpoint_two,
        output setpoint_three, output setpoint_four, output checksum_ok,
        input ready
    );
    modport sink (
        input valid, input command, input setpoint_one, input setpoint_two,
        input setpoint_three, input setpoint_four, input checksum_ok,
        output ready
    );
endinterface

[rtl/sbpd_collector.sv]
// sync hunt, byte collection and running xor of the packet deframer
// depends on sbpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbpd_collector (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_sync_value,
    output sbpd_pkg::t_result_xfer o_xfer
);

    sbpd_pkg::t_pos r_pos;
    logic [7:0]     r_xor;
    logic [7:0]     r_shift [sbpd_pkg::SHIFT_LEN];

    logic w_idle;
    logic w_last;

    assign w_idle = (r_pos == '0);
    assign w_last = (r_pos == sbpd_pkg::BODY_LEN);

    // position counter and running xor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_xor <= '0;
        end else if (i_accept) begin
            priority if (w_idle) begin
                if (i_rx_byte == i_sync_value) begin
                    r_pos <= 4'd1;
                    r_xor <= i_rx_byte;
                end
            end else if (w_last) begin
                r_pos <= '0;
                r_xor <= '0;
            end else begin
                r_pos <= r_pos + 4'd1;
                r_xor <= r_xor ^ i_rx_byte;
            end
        end
    end

    // body bytes after sync, newest at index zero
    always_ff @(posedge i_clk) begin
        if (i_accept && !w_idle && !w_last) begin
            r_shift[0] <= i_rx_byte;
            for (int i = 1; i < sbpd_pkg::SHIFT_LEN; i++) begin
                r_shift[i] <= r_shift[i-1];
            end
        end
    end

    // packet fields, valid when the checksum byte is taken
    always_comb begin
        o_xfer.done                = i_accept && w_last;
        o_xfer.data.command        = r_shift[8];
        o_xfer.data.setpoint_one   = $signed({r_shift[6], r_shift[7]});
        o_xfer.data.setpoint_two   = $signed({r_shift[4], r_shift[5]});
        o_xfer.data.setpoint_three = $signed({r_shift[2], r_shift[3]});
        o_xfer.data.setpoint_four  = $signed({r_shift[0], r_shift[1]});
        o_xfer.data.checksum_ok    = (r_xor == i_rx_byte);
    end

    `SBPD_NEVER(a_pos_range, i_clk, i_rst_n, r_pos > sbpd_pkg::BODY_LEN)
    `SBPD_ASSERT(a_done_clears, i_clk, i_rst_n, o_xfer.done |=> (r_pos == '0 && r_xor == '0))
    `SBPD_ASSERT(a_hunt_holds, i_clk, i_rst_n, (i_accept && w_idle && i_rx_byte != i_sync_value) |=> r_pos == '0)

endmodule

[rtl/sbpd_out_reg.sv]
// result register between the collector and the result channel
// depends on sbpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbpd_out_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sbpd_pkg::t_result_xfer i_xfer,
    output logic                   o_space,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sbpd_pkg::t_result      o_data
);

    logic              r_valid;
    sbpd_pkg::t_result r_data;

    // room for a new result when empty or when the held one leaves now
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_xfer.done) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_xfer.done) begin
            r_data <= i_xfer.data;
        end
    end

    `SBPD_NEVER(a_no_overwrite, i_clk, i_rst_n, i_xfer.done && r_valid && !i_ready)

endmodule

[rtl/sync_byte_packet_deframer.sv]
// top level of the sync byte packet deframer
// depends on sbpd_pkg, sbpd_byte_if, sbpd_result_if, sbpd_collector, sbpd_out_reg

// Takes one received byte per clock cycle on i_in. Bytes are dropped until one
// equals the sync register (reset 0xAA); that byte and the next ten form a
// packet of sync, command, four little-endian signed 16-bit setpoints and an
// xor checksum. No resync inside a packet. On the eleventh byte one result
// transfer is presented on o_out in the following cycle, carrying the fields
// and checksum_ok (xor of the first ten bytes equals the last); bad packets
// are reported, not dropped. The input stays ready every cycle while the
// single result register is empty or being drained, so input stalls only
// while a finished result waits on o_out. The sync register is written via
// i_cfg_we / i_cfg_wdata and should be changed only between packets.
module sync_byte_packet_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    sbpd_byte_if.sink            i_in,
    sbpd_result_if.source        o_out
);

    logic [7:0]             r_sync_value;
    logic                   w_accept;
    logic                   w_space;
    sbpd_pkg::t_result_xfer w_xfer;
    sbpd_pkg::t_result      w_data;

    // sync value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= sbpd_pkg::SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync_value <= i_cfg_wdata;
        end
    end

    // input handshake
    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    sbpd_collector u_collector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_rx_byte    (i_in.rx_byte),
        .i_sync_value (r_sync_value),
        .o_xfer       (w_xfer)
    );

    sbpd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xfer  (w_xfer),
        .o_space (w_space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_data)
    );

    // result channel payload
    assign o_out.command        = w_data.command;
    assign o_out.setpoint_one   = w_data.setpoint_one;
    assign o_out.setpoint_two   = w_data.setpoint_two;
    assign o_out.setpoint_three = w_data.setpoint_three;
    assign o_out.setpoint_four  = w_data.setpoint_four;
    assign o_out.checksum_ok    = w_data.checksum_ok;

endmodule

[verif/tb_sync_byte_packet_deframer.sv]
// testbench of the sync byte packet deframer: directed frames, then random traffic
// depends on sbpd_pkg, sbpd_byte_if, sbpd_result_if and sync_byte_packet_deframer
// a packet predictor checks every result transfer field by field
module tb_sync_byte_packet_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles the result path may still be busy after the last expected packet
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;

    sbpd_byte_if byte_ch ();
    sbpd_result_if res_ch ();

    sync_byte_packet_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_ch),
        .o_out       (res_ch)
    );

    // predictor state
    logic [7:0]     pred_sync;
    sbpd_pkg::t_pos pred_pos;
    logic [7:0]     pred_bytes [10];
    logic [7:0]     pred_xor;

    sbpd_pkg::t_result packets_due [$];
    int                error_count;
    bit                idle_on;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // advance the predictor by one accepted byte, returns 1 when a packet completes
    function automatic bit deframe_byte(input logic [7:0] b, output sbpd_pkg::t_result pkt);
        pkt = '0;
        if (pred_pos == '0) begin
            if (b == pred_sync) begin
                pred_bytes[0] = b;
                pred_xor = b;
                pred_pos = 4'd1;
            end
            return 1'b0;
        end
        if (pred_pos < sbpd_pkg::BODY_LEN) begin
            pred_bytes[pred_pos] = b;
            pred_xor = pred_xor ^ b;
            pred_pos = pred_pos + 4'd1;
            return 1'b0;
        end
        pkt.command        = pred_bytes[1];
        pkt.setpoint_one   = {pred_bytes[3], pred_bytes[2]};
        pkt.setpoint_two   = {pred_bytes[5], pred_bytes[4]};
        pkt.setpoint_three = {pred_bytes[7], pred_bytes[6]};
        pkt.setpoint_four  = {pred_bytes[9], pred_bytes[8]};
        pkt.checksum_ok    = (pred_xor == b);
        pred_pos = '0;
        pred_xor = 8'h00;
        return 1'b1;
    endfunction

    // one byte transfer, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        sbpd_pkg::t_result pkt;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        if (deframe_byte(b, pkt))
            packets_due.push_back(pkt);
    endtask

    // full packet starting with the current sync value; payload is {sp4, sp3, sp2, sp1, cmd}
    task automatic send_frame(input logic [71:0] payload, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = pred_sync;
        send_byte(pred_sync);
        for (int i = 0; i < 9; i++) begin
            b = payload[8*i +: 8];
            sum = sum ^ b;
            send_byte(b);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    function automatic logic [71:0] random_payload();
        return {$urandom, $urandom, 8'($urandom)};
    endfunction

    // sync register write once the result path has gone quiet
    task automatic write_sync(input logic [7:0] value);
        byte_ch.valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pred_sync = value;
    endtask

    // result receiver with random stall bursts
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // compare each result transfer with the oldest predicted packet
    initial begin
        sbpd_pkg::t_result got;
        sbpd_pkg::t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.command        = res_ch.command;
                got.setpoint_one   = res_ch.setpoint_one;
                got.setpoint_two   = res_ch.setpoint_two;
                got.setpoint_three = res_ch.setpoint_three;
                got.setpoint_four  = res_ch.setpoint_four;
                got.checksum_ok    = res_ch.checksum_ok;
                if (packets_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%t unexpected packet cmd=%h sp=%0d %0d %0d %0d ok=%b",
                                 $realtime, got.command, got.setpoint_one, got.setpoint_two,
                                 got.setpoint_three, got.setpoint_four, got.checksum_ok);
                end else begin
                    want = packets_due.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%t packet mismatch", $realtime);
                            $display("  expected cmd=%h sp=%0d %0d %0d %0d ok=%b",
                                     want.command, want.setpoint_one, want.setpoint_two,
                                     want.setpoint_three, want.setpoint_four, want.checksum_ok);
                            $display("  actual   cmd=%h sp=%0d %0d %0d %0d ok=%b",
                                     got.command, got.setpoint_one, got.setpoint_two,
                                     got.setpoint_three, got.setpoint_four, got.checksum_ok);
                        end
                    end
                end
            end
        end
    end

    // hunting drops other bytes; field extremes in a good packet
    task automatic test_hunt_and_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_frame({16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 8'h00}, 1'b0);
    endtask

    // sync bytes inside a packet are data; bad checksum is still reported
    task automatic test_sync_in_packet_and_bad_sum();
        send_frame({16'hAAAA, 16'h00AA, 16'h1234, 16'hAA55, 8'hFF}, 1'b1);
    endtask

    // sync change mid packet: packet carries on, new value used once hunting again
    task automatic test_sync_write_mid_packet();
        send_byte(pred_sync);
        repeat (3) send_byte(8'($urandom));
        write_sync(8'h3C);
        repeat (7) send_byte(8'($urandom));
        send_byte(8'hAA);
        send_frame(random_payload(), 1'b0);
    endtask

    // mostly well formed packets, with noise, bad sums and truncated packets
    task automatic test_random_traffic(input logic [7:0] sync, input int packets);
        int kind;
        write_sync(sync);
        for (int n = 0; n < packets; n++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_frame(random_payload(), 1'b0);
            end else if (kind == 7) begin
                send_frame(random_payload(), 1'b1);
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else begin
                send_byte(pred_sync);
                repeat ($urandom_range(1, 9)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        error_count = 0;
        idle_on     = 1'b1;
        pred_sync   = sbpd_pkg::SYNC_RESET;
        pred_pos    = '0;
        pred_xor    = 8'h00;
        for (int i = 0; i < 10; i++) pred_bytes[i] = 8'h00;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 8'h00;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_hunt_and_extremes();
        test_sync_in_packet_and_bad_sum();
        test_sync_write_mid_packet();
        test_random_traffic(8'h00, 37);
        test_random_traffic(8'hFF, 37);
        test_random_traffic(8'($urandom), 37);
        test_random_traffic(8'($urandom), 37);
        // last part back to back on both sides
        idle_on = 1'b0;
        test_random_traffic(sbpd_pkg::SYNC_RESET, 37);

        // drain
        byte_ch.valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
